@@ src/itoa_pkg.sv @@
package itoa_pkg;

	// bits of the dividend consumed per cycle by the shared divide step
	localparam int STEP_BITS = 8;

	localparam logic [5:0] RADIX_RESET = 6'd10;
	localparam logic [5:0] RADIX_MIN   = 6'd2;
	localparam logic [5:0] RADIX_MAX   = 6'd36;
	localparam logic [5:0] RADIX_DEC   = 6'd10;
	localparam logic [5:0] DIGIT_NINE  = 6'd9;
	localparam logic [5:0] DIGIT_TEN   = 6'd10;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_READ,
		ST_EMIT
	} state_t;

	function automatic logic [7:0] digit_char(input logic [5:0] d);
		logic [7:0] c;
		if (d > DIGIT_NINE) begin
			c = CHAR_A + {2'b00, d - DIGIT_TEN};
		end else begin
			c = CHAR_ZERO + {2'b00, d};
		end
		return c;
	endfunction

endpackage

@@ src/integer_to_ascii_radix_top.sv @@
// channel   direction  handshake               payload
// input     in         in_valid / in_ready     value
// output    out        out_valid / out_ready   character, last
// config    in         cfg_wr_en               cfg_wr_data (radix)
//
// one item: accept, then for each digit the whole word goes through the shared
//   divide-by-radix unit a byte at a time (8 quotient bits a cycle), then each
//   character is read from the digit ram and then presented, after a minus sign if any
// 32-bit word, base ten: at most 10 digits
// in_ready is high only while idle; a stalled out_ready holds the current character
// reset returns to idle with radix 10; the digit ram needs no clearing
module integer_to_ascii_radix_top #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [5:0]           cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [WORD_BITS-1:0] value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           character,
	output logic                 last
);

	import itoa_pkg::*;

	localparam int CHUNKS   = (WORD_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int PAD_BITS = CHUNKS * STEP_BITS;
	localparam int IDX_W    = $clog2(WORD_BITS);
	localparam int CNT_W    = $clog2(WORD_BITS + 1);
	localparam int CHK_W    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

	state_t state_q, state_d;

	logic [5:0]           radix_q;
	logic [5:0]           eff_radix;
	logic [5:0]           base_q;
	logic                 neg_q;
	logic [PAD_BITS-1:0]  word_q;
	logic [5:0]           rem_q;
	logic                 qnz_q;
	logic [CHK_W-1:0]     chunk_q;
	logic [CNT_W-1:0]     nd_q;
	logic [IDX_W-1:0]     idx_q;

	logic                 neg_in;
	logic [WORD_BITS-1:0] mag;
	logic [5:0]           r;
	logic [6:0]           t;
	logic [STEP_BITS-1:0] q;
	logic                 div_last;
	logic                 q_nonzero;
	logic                 wr_en;
	logic                 rd_en;
	logic [5:0]           rd_data;

	// radix register, out-of-range codes clamp to the nearest legal base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_wr_en) begin
			radix_q <= cfg_wr_data;
		end
	end

	always_comb begin
		if (radix_q < RADIX_MIN) begin
			eff_radix = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			eff_radix = RADIX_MAX;
		end else begin
			eff_radix = radix_q;
		end
	end

	assign neg_in = (eff_radix == RADIX_DEC) && value[WORD_BITS-1];
	assign mag    = neg_in ? (~value + 1'b1) : value;

	// shared divide step: restoring division, one byte of dividend a cycle
	always_comb begin
		r = rem_q;
		t = '0;
		q = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			t = {r, word_q[PAD_BITS-1-i]};
			if (t >= {1'b0, base_q}) begin
				r = 6'(t - {1'b0, base_q});
				q[STEP_BITS-1-i] = 1'b1;
			end else begin
				r = t[5:0];
			end
		end
	end

	assign div_last  = (chunk_q == CHK_W'(CHUNKS - 1));
	assign q_nonzero = qnz_q | (|q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		character = digit_char(rd_data);
		last      = 1'b0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_last) begin
					wr_en = 1'b1;
					if (!q_nonzero) begin
						state_d = neg_q ? ST_SIGN : ST_READ;
					end
				end
			end
			ST_SIGN: begin
				out_valid = 1'b1;
				character = CHAR_MINUS;
				if (out_ready) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				last      = (idx_q == '0);
				if (out_ready) begin
					state_d = (idx_q == '0) ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= '0;
			nd_q    <= '0;
			idx_q   <= '0;
			qnz_q   <= 1'b0;
			neg_q   <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && in_valid) begin
				chunk_q <= '0;
				nd_q    <= '0;
				qnz_q   <= 1'b0;
				neg_q   <= neg_in;
			end else if (state_q == ST_DIV) begin
				if (div_last) begin
					// digit done, the quotient becomes the next dividend
					chunk_q <= '0;
					qnz_q   <= 1'b0;
					nd_q    <= nd_q + 1'b1;
					idx_q   <= nd_q[IDX_W-1:0];
				end else begin
					chunk_q <= chunk_q + 1'b1;
					qnz_q   <= q_nonzero;
				end
			end else if (state_q == ST_EMIT && out_ready && idx_q != '0) begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			word_q <= PAD_BITS'(mag);
			rem_q  <= '0;
			base_q <= eff_radix;
		end else if (state_q == ST_DIV) begin
			word_q <= (word_q << STEP_BITS) | PAD_BITS'(q);
			rem_q  <= div_last ? 6'd0 : r;
		end
	end

	// digits are stored least significant first and read back in reverse
	itoa_ram #(
		.WIDTH (6),
		.DEPTH (WORD_BITS)
	) u_digits (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (nd_q[IDX_W-1:0]),
		.wr_data (r),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	a_busy_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted while a character is pending");

	a_base_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (base_q >= RADIX_MIN && base_q <= RADIX_MAX))
		else $error("divisor outside legal radix range");

	a_digit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nd_q <= CNT_W'(WORD_BITS))
		else $error("digit count overflow");

	a_accept_divides: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_DIV))
		else $error("accepted item did not start division");

	a_emit_has_digits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (nd_q != '0))
		else $error("character offered with no stored digits");

endmodule

@@ src/itoa_ram.sv @@
module itoa_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
